[hdl/matrix_keypad_scan_settings_macros.svh]
// Assertion macros shared by the keypad scanner checkers.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef MATRIX_KEYPAD_SCAN_SETTINGS_MACROS_SVH
`define MATRIX_KEYPAD_SCAN_SETTINGS_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MKS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("keypad scanner check failed");

// Consequent must hold in the cycle after the antecedent.
`define MKS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("keypad scanner check failed");

`endif

[hdl/mks_pkg.sv]
// Shared types and constants for the keypad scanner with settings menu.
// No dependencies; imported by every module of the block.
`default_nettype none
package mks_pkg;

	localparam int unsigned CntW   = 16;
	localparam int unsigned KeyW   = 5;
	localparam int unsigned RowW   = 2;
	localparam int unsigned ScrW   = 2;
	localparam int unsigned SetW   = 7;

	localparam logic [CntW-1:0] DebounceReset = 16'd2;
	localparam logic [RowW-1:0] LastRow       = 2'd3;
	localparam logic [KeyW-1:0] KeyNone       = 5'd0;
	localparam logic [KeyW-1:0] KeyScreen     = 5'd4;
	localparam logic [KeyW-1:0] KeyUp         = 5'd5;
	localparam logic [KeyW-1:0] KeyDown       = 5'd8;
	localparam logic [ScrW-1:0] ScreenLast    = 2'd2;
	localparam logic [ScrW-1:0] ScreenSet     = 2'd2;
	localparam logic [SetW-1:0] SetMax        = 7'd99;
	localparam logic [SetW-1:0] SetReset      = 7'd25;

	typedef enum logic [2:0] {
		PH_CHECK   = 3'b001,
		PH_WAIT    = 3'b010,
		PH_RELEASE = 3'b100
	} phase_t;

	// Outcome of one scan tick, handed to the menu logic and the output register.
	typedef struct packed {
		logic            done;
		logic [KeyW-1:0] key;
		logic [RowW-1:0] row;
	} scan_evt_t;

endpackage
`default_nettype wire

[hdl/mks_scan.sv]
// Row/column scan sequencer with debounce counter and release wait.
// Depends on mks_pkg.
`default_nettype none
module mks_scan (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        step,
	input  wire [1:0]                  col_levels,
	input  wire [mks_pkg::CntW-1:0]    debounce_ticks,
	output mks_pkg::scan_evt_t         evt
);
	import mks_pkg::*;

	logic [RowW-1:0] row_q, row_n;
	logic            col_q, col_n;
	phase_t          phase_q, phase_n;
	logic [CntW-1:0] cnt_q, cnt_n;
	logic [KeyW-1:0] found_q, found_n;
	logic            pressed;
	logic            adv;
	logic            done;

	assign pressed = ~col_levels[col_q];

	always_comb begin
		phase_n = phase_q;
		cnt_n   = cnt_q;
		found_n = found_q;
		adv     = 1'b0;
		unique case (phase_q)
			PH_WAIT: begin
				if (cnt_q != '0) begin
					cnt_n = cnt_q - 1'b1;
				end else if (pressed) begin
					// code is 4*(row+1)+col
					found_n = {3'(row_q) + 3'd1, 1'b0, col_q};
					phase_n = PH_RELEASE;
				end else begin
					adv = 1'b1;
				end
			end
			PH_RELEASE: begin
				if (!pressed) begin
					adv = 1'b1;
				end
			end
			default: begin
				if (pressed) begin
					cnt_n   = debounce_ticks;
					phase_n = PH_WAIT;
				end else begin
					adv = 1'b1;
				end
			end
		endcase

		row_n = row_q;
		col_n = col_q;
		done  = 1'b0;
		if (adv) begin
			phase_n = PH_CHECK;
			col_n   = ~col_q;
			if (col_q) begin
				if (row_q == LastRow) begin
					row_n = '0;
					done  = 1'b1;
				end else begin
					row_n = row_q + 1'b1;
				end
			end
		end
		if (done) begin
			found_n = KeyNone;
		end
	end

	assign evt.done = done;
	assign evt.key  = done ? found_q : KeyNone;
	assign evt.row  = row_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q   <= '0;
			col_q   <= 1'b0;
			phase_q <= PH_CHECK;
			cnt_q   <= '0;
			found_q <= KeyNone;
		end else if (step) begin
			row_q   <= row_n;
			col_q   <= col_n;
			phase_q <= phase_n;
			cnt_q   <= cnt_n;
			found_q <= found_n;
		end
	end

endmodule
`default_nettype wire

[hdl/mks_menu.sv]
// Screen selector and saturating setting, driven by keys from finished passes.
// Depends on mks_pkg.
`default_nettype none
module mks_menu (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        step,
	input  mks_pkg::scan_evt_t         evt,
	output logic [mks_pkg::ScrW-1:0]   screen_n,
	output logic [mks_pkg::SetW-1:0]   setting_n
);
	import mks_pkg::*;

	logic [ScrW-1:0] screen_q;
	logic [SetW-1:0] setting_q;

	always_comb begin
		screen_n  = screen_q;
		setting_n = setting_q;
		if (evt.key == KeyScreen) begin
			screen_n = (screen_q >= ScreenLast) ? '0 : screen_q + 1'b1;
		end
		// adjust only on the settings screen, after any screen change
		if (screen_n == ScreenSet) begin
			if (evt.key == KeyUp && setting_q < SetMax) begin
				setting_n = setting_q + 1'b1;
			end
			if (evt.key == KeyDown && setting_q != '0) begin
				setting_n = setting_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_q  <= '0;
			setting_q <= SetReset;
		end else if (step) begin
			screen_q  <= screen_n;
			setting_q <= setting_n;
		end
	end

endmodule
`default_nettype wire

[hdl/matrix_keypad_scan_settings.sv]
// Top level of the debounced 4x2 keypad scanner with settings menu.
// Depends on mks_pkg, mks_scan and mks_menu.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_ready  | col_levels
//  out     | out_valid / out_ready| row_drive, scan_done, key_code, screen,
//          |                      | setting_value
//  cfg     | cfg_wr_en            | cfg_wr_data (debounce_ticks)
//
// One tick per word: each accepted word updates the scan state and loads the
// output register in the same cycle, so a word can be taken every cycle unless out_ready stalls.
// in_ready is high while the output register is empty or being drained.
// A stall on out_ready holds the result and blocks input until it is taken.
// Reset: row 0, check phase, screen 0, setting 25, debounce 2.
`default_nettype none
module matrix_keypad_scan_settings (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        in_valid,
	output logic                       in_ready,
	input  wire [1:0]                  col_levels,
	output logic                       out_valid,
	input  wire                        out_ready,
	output logic [3:0]                 row_drive,
	output logic                       scan_done,
	output logic [mks_pkg::KeyW-1:0]   key_code,
	output logic [mks_pkg::ScrW-1:0]   screen,
	output logic [mks_pkg::SetW-1:0]   setting_value,
	input  wire                        cfg_wr_en,
	input  wire [mks_pkg::CntW-1:0]    cfg_wr_data
);
	import mks_pkg::*;

	logic            step;
	logic [CntW-1:0] debounce_q;
	scan_evt_t       evt;
	logic [ScrW-1:0] screen_n;
	logic [SetW-1:0] setting_n;

	assign in_ready = !out_valid || out_ready;
	assign step     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DebounceReset;
		end else if (cfg_wr_en) begin
			debounce_q <= cfg_wr_data;
		end
	end

	mks_scan u_scan (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.col_levels     (col_levels),
		.debounce_ticks (debounce_q),
		.evt            (evt)
	);

	mks_menu u_menu (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.evt       (evt),
		.screen_n  (screen_n),
		.setting_n (setting_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (step) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// payload registers: load on accept, hold otherwise
	always_ff @(posedge clk) begin
		if (step) begin
			row_drive     <= ~(4'b0001 << evt.row);
			scan_done     <= evt.done;
			key_code      <= evt.key;
			screen        <= screen_n;
			setting_value <= setting_n;
		end
	end

endmodule
`default_nettype wire

[hdl/mks_checker.sv]
// Port-level checker for the keypad scanner, bound to the top level.
// Depends on mks_pkg and matrix_keypad_scan_settings_macros.svh.
`default_nettype none
`include "matrix_keypad_scan_settings_macros.svh"
module mks_checker (
	input wire                        clk,
	input wire                        arst_n,
	input wire                        in_valid,
	input wire                        in_ready,
	input wire [1:0]                  col_levels,
	input wire                        out_valid,
	input wire                        out_ready,
	input wire [3:0]                  row_drive,
	input wire                        scan_done,
	input wire [mks_pkg::KeyW-1:0]    key_code,
	input wire [mks_pkg::ScrW-1:0]    screen,
	input wire [mks_pkg::SetW-1:0]    setting_value,
	input wire                        cfg_wr_en,
	input wire [mks_pkg::CntW-1:0]    cfg_wr_data
);
	import mks_pkg::*;

	`MKS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(key_code))
	`MKS_ASSERT_NOW(a_key_only_on_done, out_valid && !scan_done, key_code == KeyNone)
	`MKS_ASSERT_NOW(a_key_shape, out_valid && key_code != KeyNone, key_code[1] == 1'b0 && key_code[4:2] != 3'd0)
	`MKS_ASSERT_NOW(a_menu_range, out_valid, screen != 2'd3 && setting_value <= SetMax)
	`MKS_ASSERT_NOW(a_row_onehot, out_valid, $onehot(~row_drive))

endmodule

bind matrix_keypad_scan_settings mks_checker u_mks_checker (.*);
`default_nettype wire
